// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: hw/rtl/fbd_pkg.sv
// Package for the fractional baud divider search.
// Holds widths, sequencer states and the ratio ROM. No dependencies.
package fbd_pkg;
   localparam int CLK_W = 28;
   localparam int BAUD_W = 22;
   localparam int DIV_W = 16;
   localparam int NUM_W = 38;
   localparam int DEN_W = 37;
   localparam int DQ_W = CLK_W - 4;
   localparam int RATIO_ENTRIES_DEF = 72;
   localparam int ROM_SIZE = 72;
   localparam int START_POS = 36;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_ERR = 2'd1;
   localparam logic [1:0] ST_BIG = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_EXACT, S_EXWAIT, S_DIV, S_DIVWAIT, S_MUL, S_CMP, S_DONE
   } state_type;

   function automatic logic [10:0] rom_milli(input logic [6:0] p);
      logic [10:0] t [0:ROM_SIZE-1];
      t = '{11'd1000, 11'd1067, 11'd1071, 11'd1077, 11'd1083, 11'd1091, 11'd1100,
         11'd1111, 11'd1125, 11'd1133, 11'd1143, 11'd1154, 11'd1167, 11'd1182,
         11'd1200, 11'd1214, 11'd1222, 11'd1231, 11'd1250, 11'd1267, 11'd1273,
         11'd1286, 11'd1300, 11'd1308, 11'd1333, 11'd1357, 11'd1364, 11'd1375,
         11'd1385, 11'd1400, 11'd1417, 11'd1429, 11'd1444, 11'd1455, 11'd1462,
         11'd1467, 11'd1500, 11'd1533, 11'd1538, 11'd1545, 11'd1556, 11'd1571,
         11'd1583, 11'd1600, 11'd1615, 11'd1625, 11'd1636, 11'd1643, 11'd1667,
         11'd1692, 11'd1700, 11'd1714, 11'd1727, 11'd1733, 11'd1750, 11'd1769,
         11'd1778, 11'd1786, 11'd1800, 11'd1818, 11'd1833, 11'd1846, 11'd1857,
         11'd1867, 11'd1875, 11'd1889, 11'd1900, 11'd1909, 11'd1917, 11'd1923,
         11'd1929, 11'd1933};
      return (p >= 7'(ROM_SIZE)) ? t[ROM_SIZE-1] : t[p];
   endfunction

   function automatic logic [7:0] rom_pair(input logic [6:0] p);
      logic [7:0] t [0:ROM_SIZE-1];
      t = '{8'h01, 8'h1F, 8'h1E, 8'h1D, 8'h1C, 8'h1B, 8'h1A, 8'h19, 8'h18, 8'h2F,
         8'h17, 8'h2D, 8'h16, 8'h2B, 8'h15, 8'h3E, 8'h29, 8'h3D, 8'h14, 8'h4F,
         8'h3B, 8'h27, 8'h3A, 8'h4D, 8'h13, 8'h5E, 8'h4B, 8'h38, 8'h5D, 8'h25,
         8'h5C, 8'h37, 8'h49, 8'h5B, 8'h6D, 8'h7F, 8'h12, 8'h8F, 8'h7D, 8'h6B,
         8'h59, 8'h47, 8'h7C, 8'h35, 8'h8D, 8'h58, 8'h7B, 8'h9E, 8'h23, 8'h9D,
         8'h7A, 8'h57, 8'h8B, 8'hBF, 8'h34, 8'hAD, 8'h79, 8'hBE, 8'h45, 8'h9B,
         8'h56, 8'hBD, 8'h67, 8'hDF, 8'h78, 8'h89, 8'h9A, 8'hAB, 8'hBC, 8'hCD,
         8'hDE, 8'hEF};
      return (p >= 7'(ROM_SIZE)) ? t[ROM_SIZE-1] : t[p];
   endfunction
endpackage

// File: hw/rtl/fractional_baud_divider_search_top.sv
// Fractional baud divider search: sequencer around one shared divider.
// A zero baud rate is answered via S_DONE with no division; an exact division ends
// it on a zero remainder; else one division follows per step of the 72-entry table.
// One transaction at a time; next request taken the cycle after the response is accepted.
// The bit-serial divider is reused for the exact division and for every table step.
// Synchronous active-high reset; clock_hz resets to 25000000.
module fractional_baud_divider_search_top
   import fbd_pkg::*;
#(
   parameter int RATIO_ENTRIES = RATIO_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CLK_W-1:0]  csr_clock_hz,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BAUD_W-1:0] req_baud_rate,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DIV_W-1:0]  rsp_divisor_latch,
   output logic [3:0]        rsp_div_add_value,
   output logic [3:0]        rsp_mul_value,
   output logic [1:0]        rsp_status
);
   localparam logic [6:0] LAST = 7'(RATIO_ENTRIES - 1);
   localparam logic [6:0] STARTP = (START_POS < RATIO_ENTRIES - 1) ?
                                   7'(START_POS) : 7'(RATIO_ENTRIES - 1);
   localparam int PROD_W = NUM_W + BAUD_W + 9;

   state_type st_ff, st_in;
   logic [CLK_W-1:0] clk_ff, clk_in;
   logic [BAUD_W+3:0] b16_ff, b16_in;
   logic [6:0] pos_ff, pos_in;
   logic [NUM_W-1:0] d_ff, d_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic down_ff, down_in;
   logic rv_ff, rv_in;
   logic [DIV_W-1:0] od_ff, od_in;
   logic [3:0] oa_ff, oa_in, om_ff, om_in;
   logic [1:0] os_ff, os_in;
   logic div_start, div_busy;
   logic [NUM_W-1:0] dnum, quo;
   logic [DEN_W-1:0] dden, rem;
   logic [CLK_W+3:0] clk10;
   logic [BAUD_W+DQ_W+3:0] mul_w;
   logic [7:0] pair;

   fbd_divider u_div (.clock, .reset, .start(div_start), .num(dnum), .den(dden),
      .busy(div_busy), .quo, .rem);

   assign clk10 = 32'(clk_ff) * 32'd10;
   assign pair = rom_pair(pos_ff);
   // a divisor never exceeds clock_hz / 16
   assign mul_w = b16_ff * d_ff[DQ_W-1:0];

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE:    if (req_valid && !rv_ff) st_in = (req_baud_rate == '0) ? S_DONE : S_EXACT;
         S_EXACT:   st_in = S_EXWAIT;
         S_EXWAIT:  if (!div_busy) st_in = (rem == '0) ? S_IDLE : S_DIV;
         S_DIV:     st_in = S_DIVWAIT;
         S_DIVWAIT: if (!div_busy) st_in = S_MUL;
         S_MUL:     st_in = S_CMP;
         S_CMP:     st_in = (prod_in == '1) ? S_DIV : S_IDLE;
         S_DONE:    st_in = S_IDLE;
         default:   st_in = S_IDLE;
      endcase
   end

   always_comb begin
      clk_in = clk_ff; b16_in = b16_ff; pos_in = pos_ff; d_in = d_ff;
      prod_in = prod_ff; down_in = down_ff; rv_in = rv_ff;
      od_in = od_ff; oa_in = oa_ff; om_in = om_ff; os_in = os_ff;
      div_start = 1'b0; dnum = '0; dden = '0;
      req_ready = (st_ff == S_IDLE) && !rv_ff;
      csr_ready = 1'b1;
      if (csr_valid) clk_in = csr_clock_hz;
      if (rsp_valid && rsp_ready) rv_in = 1'b0;
      unique case (st_ff)
         S_IDLE: if (req_valid && !rv_ff) begin
            b16_in = {req_baud_rate, 4'b0};
            pos_in = STARTP; down_in = 1'b0;
            if (req_baud_rate == '0) begin
               od_in = '0; oa_in = '0; om_in = 4'd1; os_in = ST_ERR;
            end
         end
         S_EXACT: begin
            div_start = 1'b1; dnum = NUM_W'(clk_ff); dden = DEN_W'(b16_ff);
         end
         S_EXWAIT: if (!div_busy && rem == '0) begin
            d_in = quo; oa_in = '0; om_in = 4'd1;
            if (quo == '0) begin od_in = '0; os_in = ST_ERR; end
            else if (quo > NUM_W'(16'hFFFF)) begin od_in = '1; os_in = ST_BIG; end
            else begin od_in = quo[DIV_W-1:0]; os_in = ST_OK; end
         end
         S_DIV: begin
            div_start = 1'b1; dnum = NUM_W'(clk_ff) * NUM_W'(1000);
            dden = DEN_W'(b16_ff) * DEN_W'(rom_milli(pos_ff));
         end
         S_DIVWAIT: if (!div_busy) d_in = quo;
         S_MUL: prod_in = PROD_W'(mul_w);
         S_CMP: begin
            prod_in = '0;
            if (!down_ff && PROD_W'(clk10) < prod_ff * 11) begin
               if (pos_ff >= LAST) begin
                  od_in = '0; oa_in = '0; om_in = 4'd1; os_in = ST_ERR; rv_in = 1'b1;
               end else begin pos_in = pos_ff + 7'd1; prod_in = '1; end
            end else if (PROD_W'(clk10) > prod_ff * 19) begin
               down_in = 1'b1;
               if (pos_ff == '0) begin
                  od_in = '0; oa_in = '0; om_in = 4'd1; os_in = ST_ERR; rv_in = 1'b1;
               end else begin pos_in = pos_ff - 7'd1; prod_in = '1; end
            end else begin
               oa_in = pair[7:4]; om_in = pair[3:0]; rv_in = 1'b1;
               if (d_ff == '0) begin
                  od_in = '0; oa_in = '0; om_in = 4'd1; os_in = ST_ERR;
               end else if (d_ff > NUM_W'(16'hFFFF)) begin od_in = '1; os_in = ST_BIG; end
               else begin od_in = d_ff[DIV_W-1:0]; os_in = ST_OK; end
            end
         end
         S_DONE: rv_in = 1'b1;
         default: ;
      endcase
      if (st_ff == S_EXWAIT && !div_busy && rem == '0) rv_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; clk_ff <= CLK_W'(25000000); rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         clk_ff <= clk_in; rv_ff <= rv_in;
      end
      b16_ff <= b16_in; pos_ff <= pos_in; d_ff <= d_in; prod_ff <= prod_in;
      down_ff <= down_in; od_ff <= od_in; oa_ff <= oa_in; om_ff <= om_in; os_ff <= os_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_divisor_latch = od_ff;
   assign rsp_div_add_value = oa_ff;
   assign rsp_mul_value = om_ff;
   assign rsp_status = os_ff;
endmodule

// File: hw/rtl/fbd_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on fbd_pkg.
module fbd_divider
   import fbd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   sh;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      sh = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den; cnt_in = 6'(NUM_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {1'b0, d_ff}) begin
            r_in = sh - {1'b0, d_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         busy_in = (cnt_ff != 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   assign busy = busy_ff;
   assign quo = q_ff;
   assign rem = r_ff[DEN_W-1:0];
endmodule

// File: hw/rtl/fbd_checker.sv
// Port-level checker for the fractional baud divider search.
// Depends on assert_macros.svh and fbd_pkg; bound to the top level.
`include "assert_macros.svh"
module fbd_checker
   import fbd_pkg::*;
(
   input logic clock, reset, req_valid, req_ready, rsp_valid, rsp_ready,
   input logic [1:0] rsp_status,
   input logic [3:0] rsp_mul_value,
   input logic [DIV_W-1:0] rsp_divisor_latch
);
   `ASSERT_IMPL(a_no_req_busy, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_IMPL(a_status, clock, reset, rsp_valid, rsp_status != 2'd3)
   `ASSERT_IMPL(a_err, clock, reset, rsp_valid && rsp_status == ST_ERR,
      rsp_divisor_latch == '0 && rsp_mul_value == 4'd1)
endmodule

bind fractional_baud_divider_search_top fbd_checker u_chk (.*);
